[sv/ast_pkg.sv]
// Shared types, constants and the arctangent table of the spherical converter.
`timescale 1ns / 1ps
package ast_pkg;

  // Field widths
  localparam int RAW_W = 16;
  localparam int CNT_W = 10;
  localparam int STEP_W = 13;
  localparam int G_W = 20;
  localparam int MAG_W = 20;
  localparam int AZ_W = 17;
  localparam int POL_W = 16;

  // Sum of squares and square-root unit
  localparam int SQ_W = 2 * G_W;
  localparam int HYP_SHIFT = 16;
  localparam int ISQ_IN_W = SQ_W + HYP_SHIFT;
  localparam int ISQ_STEPS = ISQ_IN_W / 2;
  localparam int ISQ_W = ISQ_IN_W + 1;
  localparam int ROOT_W = ISQ_STEPS;

  // CORDIC
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_LEN = 24;
  localparam int CW = 32;
  localparam int AW = 27;
  localparam int CORD_SCALE = 8;
  localparam logic signed [AW-1:0] HALF_TURN = 27'sd11796480;
  localparam logic signed [AW-1:0] ROUND_HALF = 27'sd128;
  localparam int ANGLE_MAX = 46080;

  // Step factors at 2 g
  localparam logic [STEP_W-1:0] STEP_HI = 13'd256;
  localparam logic [STEP_W-1:0] STEP_LO = 13'd1022;

  // Configuration port
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_RES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE = 1'd1;
  localparam logic [1:0] RANGE_4G = 2'd1;
  localparam logic [1:0] RANGE_8G = 2'd2;

  // Pipeline depths
  localparam int SQ_LAT = ISQ_STEPS + 1;
  localparam int CORD_LAT = CORDIC_STEPS + 1;
  localparam int PIPE_LAT = 3 + SQ_LAT + CORD_LAT + 1;
  localparam int XYZ_DLY = PIPE_LAT - 2;
  localparam int CORD_TAP = SQ_LAT + 1;

  typedef logic signed [G_W-1:0] accel_t;
  typedef logic signed [CW-1:0] cvec_t;
  typedef logic signed [AW-1:0] angle_t;
  typedef logic [ISQ_IN_W-1:0] sqin_t;
  typedef logic [ROOT_W-1:0] root_t;

  typedef struct packed {
    logic       high_res;
    logic [1:0] range_sel;
  } scale_cfg_t;

  typedef struct packed {
    accel_t x;
    accel_t y;
    accel_t z;
    logic   nz;
  } vec_t;

  // atan(2^-i) in units of 2^-16 degree, rounded
  function automatic angle_t atan_lut(input int unsigned i);
    angle_t v;
    case (i)
      0:  v = angle_t'(2949120);
      1:  v = angle_t'(1740967);
      2:  v = angle_t'(919879);
      3:  v = angle_t'(466945);
      4:  v = angle_t'(234379);
      5:  v = angle_t'(117304);
      6:  v = angle_t'(58666);
      7:  v = angle_t'(29335);
      8:  v = angle_t'(14668);
      9:  v = angle_t'(7334);
      10: v = angle_t'(3667);
      11: v = angle_t'(1833);
      12: v = angle_t'(917);
      13: v = angle_t'(458);
      14: v = angle_t'(229);
      15: v = angle_t'(115);
      16: v = angle_t'(57);
      17: v = angle_t'(29);
      18: v = angle_t'(14);
      19: v = angle_t'(7);
      20: v = angle_t'(4);
      21: v = angle_t'(2);
      22: v = angle_t'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[sv/ast_if.sv]
// Valid/ready channel interfaces for sample items and result items.
`timescale 1ns / 1ps
interface ast_in_if import ast_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [RAW_W-1:0] raw_x;
  logic signed [RAW_W-1:0] raw_y;
  logic signed [RAW_W-1:0] raw_z;
  modport source (output valid, raw_x, raw_y, raw_z, input ready);
  modport sink (input valid, raw_x, raw_y, raw_z, output ready);
endinterface

interface ast_out_if import ast_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [G_W-1:0]   x_g;
  logic signed [G_W-1:0]   y_g;
  logic signed [G_W-1:0]   z_g;
  logic [MAG_W-1:0]        magnitude;
  logic signed [AZ_W-1:0]  azimuth;
  logic [POL_W-1:0]        polar_angle;
  logic                    polar_valid;
  modport source (output valid, x_g, y_g, z_g, magnitude, azimuth, polar_angle,
                  polar_valid, input ready);
  modport sink (input valid, x_g, y_g, z_g, magnitude, azimuth, polar_angle,
                polar_valid, output ready);
endinterface

[sv/accel_sample_to_spherical_top.sv]
// Top level: accelerometer sample triple to acceleration, length and angles.
// Stages in order: scale, squares and sums, square root, CORDIC, output merge.
// Throughput: one item per cycle; every stage is a register, so a new item
//   enters each cycle while the output slot is free or being taken.
// Reset (rst_n, synchronous, active low): clears the stage valid bits and sets
//   high_resolution to 1 and range_select to 0; payload registers keep data.
`timescale 1ns / 1ps
module accel_sample_to_spherical_top import ast_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  ast_in_if.sink                in_ch,
  ast_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers
  scale_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.high_res <= 1'b1;
      cfg_r.range_sel <= 2'd0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_HIGH_RES: cfg_r.high_res <= cfg_data[0];
        REG_RANGE:    cfg_r.range_sel <= cfg_data;
        default:      cfg_r <= cfg_r;
      endcase
    end
  end

  // Global advance: the whole pipe moves when the output slot is free or taken
  logic en;
  logic [PIPE_LAT-1:0] vld_r;

  assign en = !vld_r[PIPE_LAT-1] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_LAT-2:0], in_ch.valid};
    end
  end

  // Stage 1: three scaling lanes
  accel_t x_s;
  accel_t y_s;
  accel_t z_s;

  ast_scale u_scale_x (.clk, .en, .cfg(cfg_r), .raw(in_ch.raw_x), .acc_r(x_s));
  ast_scale u_scale_y (.clk, .en, .cfg(cfg_r), .raw(in_ch.raw_y), .acc_r(y_s));
  ast_scale u_scale_z (.clk, .en, .cfg(cfg_r), .raw(in_ch.raw_z), .acc_r(z_s));

  // Triple and zero flag ride along to the merge stage
  vec_t vd_r [XYZ_DLY];

  always_ff @(posedge clk) begin
    if (en) begin
      vd_r[0] <= '{x: x_s, y: y_s, z: z_s, nz: (x_s != '0) || (y_s != '0) || (z_s != '0)};
      for (int k = 1; k < XYZ_DLY; k++) begin
        vd_r[k] <= vd_r[k-1];
      end
    end
  end

  // Stage 2: squares
  logic signed [SQ_W-1:0] xx_s;
  logic signed [SQ_W-1:0] yy_s;
  logic signed [SQ_W-1:0] zz_s;
  logic [SQ_W-1:0] xx_r;
  logic [SQ_W-1:0] yy_r;
  logic [SQ_W-1:0] zz_r;

  assign xx_s = x_s * x_s;
  assign yy_s = y_s * y_s;
  assign zz_s = z_s * z_s;

  always_ff @(posedge clk) begin
    if (en) begin
      xx_r <= xx_s;
      yy_r <= yy_s;
      zz_r <= zz_s;
    end
  end

  // Stage 3: planar and full sums of squares
  logic [SQ_W-1:0] sqxy_r;
  logic [SQ_W-1:0] sum_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sqxy_r <= xx_r + yy_r;
      sum_r <= xx_r + yy_r + zz_r;
    end
  end

  // Two square-root lanes: vector length and planar hypotenuse (x 256)
  root_t mag_root;
  root_t hyp_root;

  ast_isqrt u_sqrt_mag (
    .clk, .en,
    .rad_i({{HYP_SHIFT{1'b0}}, sum_r}),
    .root_r(mag_root)
  );

  ast_isqrt u_sqrt_hyp (
    .clk, .en,
    .rad_i({sqxy_r, {HYP_SHIFT{1'b0}}}),
    .root_r(hyp_root)
  );

  // Two CORDIC lanes: azimuth and polar angle
  vec_t   vt;
  cvec_t  cx;
  cvec_t  cy;
  cvec_t  cz;
  angle_t az_ang;
  angle_t pol_ang;

  assign vt = vd_r[CORD_TAP];
  assign cx = cvec_t'(vt.x) <<< CORD_SCALE;
  assign cy = cvec_t'(vt.y) <<< CORD_SCALE;
  assign cz = cvec_t'(vt.z) <<< CORD_SCALE;

  ast_cordic u_cordic_az (.clk, .en, .num_i(cy), .den_i(cx), .ang_o(az_ang));
  ast_cordic u_cordic_pol (
    .clk, .en,
    .num_i(cvec_t'(hyp_root)),
    .den_i(cz),
    .ang_o(pol_ang)
  );

  // Length waits for the CORDIC lanes
  logic [MAG_W-1:0] md_r [CORD_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      md_r[0] <= mag_root[MAG_W-1:0];
      for (int k = 1; k < CORD_LAT; k++) begin
        md_r[k] <= md_r[k-1];
      end
    end
  end

  // Merge: round to 1/256 degree, clamp, mask polar angle of zero vector
  vec_t   vm;
  angle_t az_rnd;
  angle_t pol_rnd;
  logic signed [AZ_W-1:0] az_fin;
  logic [POL_W-1:0] pol_fin;

  assign vm = vd_r[XYZ_DLY-1];
  assign az_rnd = (az_ang + ROUND_HALF) >>> 8;
  assign pol_rnd = (pol_ang + ROUND_HALF) >>> 8;

  always_comb begin
    if (az_rnd > angle_t'(ANGLE_MAX)) begin
      az_fin = AZ_W'(ANGLE_MAX);
    end else if (az_rnd < -angle_t'(ANGLE_MAX)) begin
      az_fin = -AZ_W'(ANGLE_MAX);
    end else begin
      az_fin = az_rnd[AZ_W-1:0];
    end

    if (!vm.nz || pol_rnd < 0) begin
      pol_fin = '0;
    end else if (pol_rnd > angle_t'(ANGLE_MAX)) begin
      pol_fin = POL_W'(ANGLE_MAX);
    end else begin
      pol_fin = pol_rnd[POL_W-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (en) begin
      out_ch.x_g <= vm.x;
      out_ch.y_g <= vm.y;
      out_ch.z_g <= vm.z;
      out_ch.magnitude <= md_r[CORD_LAT-1];
      out_ch.azimuth <= az_fin;
      out_ch.polar_angle <= pol_fin;
      out_ch.polar_valid <= vm.nz;
    end
  end

  assign out_ch.valid = vld_r[PIPE_LAT-1];

  // Checks
  a_zero_vec: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.polar_valid |->
      out_ch.magnitude == '0 && out_ch.polar_angle == '0)
    else $error("zero vector with nonzero length or polar angle");

  a_az_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.azimuth <= AZ_W'(ANGLE_MAX) &&
                     out_ch.azimuth >= -AZ_W'(ANGLE_MAX))
    else $error("azimuth out of range");

  a_pol_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.polar_angle <= POL_W'(ANGLE_MAX))
    else $error("polar angle out of range");

  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> vld_r[0])
    else $error("accepted item not captured");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> $stable(vld_r))
    else $error("pipeline moved while output stalled");

endmodule

[sv/ast_scale.sv]
// One axis lane: raw sample to acceleration in 2^-16 g.
`timescale 1ns / 1ps
module ast_scale import ast_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  scale_cfg_t              cfg,
  input  logic signed [RAW_W-1:0] raw,
  output accel_t                  acc_r
);

  logic signed [RAW_W-1:0]     biased;
  logic signed [CNT_W-1:0]     cnt;
  logic [STEP_W-1:0]           base;
  logic [STEP_W-1:0]           step;
  logic signed [CNT_W+STEP_W:0] prod;

  always_comb begin
    // divide by 64 toward zero
    biased = raw[RAW_W-1] ? raw + 16'sd63 : raw;
    cnt = cfg.high_res ? biased[RAW_W-1:6] : {{(CNT_W-8){raw[7]}}, raw[7:0]};
    base = cfg.high_res ? STEP_HI : STEP_LO;
    case (cfg.range_sel)
      RANGE_4G: step = base << 1;
      RANGE_8G: step = base << 2;
      default:  step = base;
    endcase
    prod = cnt * $signed({1'b0, step});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_r <= prod[G_W-1:0];
    end
  end

endmodule

[sv/ast_isqrt.sv]
// Pipelined rounded integer square root, one result bit per stage.
`timescale 1ns / 1ps
module ast_isqrt import ast_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  sqin_t rad_i,
  output root_t root_r
);

  logic [ISQ_W-1:0] rem_r [ISQ_STEPS];
  logic [ISQ_W-1:0] part_r [ISQ_STEPS];
  logic [ISQ_W-1:0] fin;

  for (genvar g = 0; g < ISQ_STEPS; g++) begin : g_step
    logic [ISQ_W-1:0] rem_in;
    logic [ISQ_W-1:0] part_in;
    logic [ISQ_W-1:0] bitv;
    logic [ISQ_W-1:0] trial;

    if (g == 0) begin : g_first
      assign rem_in = {1'b0, rad_i};
      assign part_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[g-1];
      assign part_in = part_r[g-1];
    end

    assign bitv = ISQ_W'(1) << (2 * (ISQ_STEPS - 1 - g));
    assign trial = part_in + bitv;

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_in >= trial) begin
          rem_r[g] <= rem_in - trial;
          part_r[g] <= (part_in >> 1) + bitv;
        end else begin
          rem_r[g] <= rem_in;
          part_r[g] <= part_in >> 1;
        end
      end
    end
  end

  // round to nearest
  assign fin = part_r[ISQ_STEPS-1] +
               ISQ_W'(rem_r[ISQ_STEPS-1] > part_r[ISQ_STEPS-1]);

  always_ff @(posedge clk) begin
    if (en) begin
      root_r <= fin[ROOT_W-1:0];
    end
  end

endmodule

[sv/ast_cordic.sv]
// Pipelined vectoring CORDIC lane: angle of (den, num) in 2^-16 degree.
`timescale 1ns / 1ps
module ast_cordic import ast_pkg::*; (
  input  logic   clk,
  input  logic   en,
  input  cvec_t  num_i,
  input  cvec_t  den_i,
  output angle_t ang_o
);

  cvec_t  x_r [CORDIC_STEPS+1];
  cvec_t  y_r [CORDIC_STEPS+1];
  angle_t a_r [CORDIC_STEPS+1];
  logic   byp_r [CORDIC_STEPS+1];

  cvec_t  x0;
  cvec_t  y0;
  angle_t a0;
  logic   byp0;

  // quadrant fold; on the x axis the angle is known at once
  always_comb begin
    byp0 = (num_i == '0);
    x0 = den_i;
    y0 = num_i;
    a0 = '0;
    if (byp0) begin
      a0 = (den_i < 0) ? HALF_TURN : '0;
    end else if (den_i < 0) begin
      a0 = (num_i > 0) ? HALF_TURN : -HALF_TURN;
      x0 = -den_i;
      y0 = -num_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= x0;
      y_r[0] <= y0;
      a_r[0] <= a0;
      byp_r[0] <= byp0;
    end
  end

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_iter
    cvec_t tx;
    cvec_t ty;
    assign tx = x_r[g] >>> g;
    assign ty = y_r[g] >>> g;

    always_ff @(posedge clk) begin
      if (en) begin
        byp_r[g+1] <= byp_r[g];
        if (y_r[g] > 0) begin
          x_r[g+1] <= x_r[g] + ty;
          y_r[g+1] <= y_r[g] - tx;
          a_r[g+1] <= byp_r[g] ? a_r[g] : a_r[g] + atan_lut(g);
        end else begin
          x_r[g+1] <= x_r[g] - ty;
          y_r[g+1] <= y_r[g] + tx;
          a_r[g+1] <= byp_r[g] ? a_r[g] : a_r[g] - atan_lut(g);
        end
      end
    end
  end

  assign ang_o = a_r[CORDIC_STEPS];

endmodule

[tb/sv/accel_sample_to_spherical_top_test.sv]
// Testbench for the sample-to-spherical converter: scaled predictor and result checks.
`timescale 1ns / 1ps
module accel_sample_to_spherical_top_test;
  import ast_pkg::*;

  // One expected result item
  typedef struct {
    accel_t                 x_g;
    accel_t                 y_g;
    accel_t                 z_g;
    logic [MAG_W-1:0]       magnitude;
    logic signed [AZ_W-1:0] azimuth;
    logic [POL_W-1:0]       polar_angle;
    logic                   polar_valid;
  } sph_result_t;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [1:0] RANGE_2G = 2'd0;
  localparam logic [1:0] RANGE_ODD = 2'd3; // unused code, acts as 2 g

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  ast_in_if  in_ch ();
  ast_out_if out_ch ();

  accel_sample_to_spherical_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  always #4 clk = ~clk;

  // Shadow of the block's configuration, same reset values
  logic       shadow_high_res = 1'b1;
  logic [1:0] shadow_range = RANGE_2G;

  sph_result_t pending_results[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_req = 0;
  int unsigned hold_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned err_cnt = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.raw_x = '0;
    in_ch.raw_y = '0;
    in_ch.raw_z = '0;
    out_ch.ready = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Arithmetic right shift rounding toward minus infinity
  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  // Integer square root, rounded to nearest
  function automatic longint unsigned root_nearest(longint unsigned n);
    longint unsigned r, b, rem;
    r = 0;
    rem = n;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (rem >= r + b) begin
        rem = rem - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    if (rem > r) r = r + 1;
    return r;
  endfunction

  // Vectoring CORDIC: angle of (den, num) in 2^-16 degree
  function automatic longint vector_angle(longint num, longint den);
    longint vx, vy, acc, tx, ty;
    vx = den;
    vy = num;
    acc = 0;
    if (num == 0) return (den < 0) ? longint'(HALF_TURN) : 0;
    if (vx < 0) begin
      acc = (vy > 0) ? longint'(HALF_TURN) : -longint'(HALF_TURN);
      vx = -vx;
      vy = -vy;
    end
    for (int i = 0; i < CORDIC_STEPS && i < ATAN_LEN; i++) begin
      tx = asr(vx, i);
      ty = asr(vy, i);
      if (vy > 0) begin
        vx = vx + ty;
        vy = vy - tx;
        acc = acc + longint'(atan_lut(i));
      end else begin
        vx = vx - ty;
        vy = vy + tx;
        acc = acc - longint'(atan_lut(i));
      end
    end
    return acc;
  endfunction

  function automatic longint deg256_clamped(longint a, longint lo, longint hi);
    longint r;
    r = asr(a + 128, 8);
    if (r < lo) r = lo;
    if (r > hi) r = hi;
    return r;
  endfunction

  function automatic longint raw_to_accel(logic [RAW_W-1:0] raw, longint stp);
    longint cnt;
    if (shadow_high_res) cnt = longint'($signed(raw)) / 64;
    else cnt = longint'($signed(raw[7:0]));
    return cnt * stp;
  endfunction

  function automatic sph_result_t predict_spherical(logic [RAW_W-1:0] rx,
                                                    logic [RAW_W-1:0] ry,
                                                    logic [RAW_W-1:0] rz);
    sph_result_t res;
    longint stp, ax, ay, az, hyp;
    longint unsigned sq_xy;
    stp = shadow_high_res ? longint'(STEP_HI) : longint'(STEP_LO);
    if (shadow_range == RANGE_4G) stp = stp * 2;
    else if (shadow_range == RANGE_8G) stp = stp * 4;
    ax = raw_to_accel(rx, stp);
    ay = raw_to_accel(ry, stp);
    az = raw_to_accel(rz, stp);
    sq_xy = ax * ax + ay * ay;
    res.x_g = accel_t'(ax);
    res.y_g = accel_t'(ay);
    res.z_g = accel_t'(az);
    res.magnitude = MAG_W'(root_nearest(sq_xy + az * az));
    res.polar_valid = !(ax == 0 && ay == 0 && az == 0);
    res.azimuth = AZ_W'(deg256_clamped(vector_angle(ay * 256, ax * 256),
                                       -ANGLE_MAX, ANGLE_MAX));
    if (res.polar_valid) begin
      hyp = longint'(root_nearest(sq_xy * 65536));
      res.polar_angle = POL_W'(deg256_clamped(vector_angle(hyp, az * 256),
                                              0, ANGLE_MAX));
    end else begin
      res.polar_angle = '0;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: ready pattern, long hold-offs, checking
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    if (hold_cnt != 0) begin
      hold_cnt = hold_cnt - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic void check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, exp_v,
               act_v);
    end
  endfunction

  always @(posedge clk) begin
    sph_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        err_cnt++;
        $display("%0t: result item with none expected, magnitude %0h", $realtime,
                 out_ch.magnitude);
      end else begin
        want = pending_results.pop_front();
        check_field("x_g", want.x_g, out_ch.x_g);
        check_field("y_g", want.y_g, out_ch.y_g);
        check_field("z_g", want.z_g, out_ch.z_g);
        check_field("magnitude", want.magnitude, out_ch.magnitude);
        check_field("azimuth", want.azimuth, out_ch.azimuth);
        check_field("polar_angle", want.polar_angle, out_ch.polar_angle);
        check_field("polar_valid", want.polar_valid, out_ch.polar_valid);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender helpers
  // ---------------------------------------------------------------------------

  // Offer one sample triple, with optional idle cycles first; returns at accept.
  task automatic send_sample(logic [RAW_W-1:0] rx, logic [RAW_W-1:0] ry,
                             logic [RAW_W-1:0] rz);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.raw_x <= rx;
    in_ch.raw_y <= ry;
    in_ch.raw_z <= rz;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(predict_spherical(rx, ry, rz));
  endtask

  // Stop offering and wait until every expected result is back
  task automatic drain;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_HIGH_RES) shadow_high_res = val[0];
    else shadow_range = val;
  endtask

  task automatic set_scale(logic hr, logic [1:0] rng);
    write_cfg(REG_HIGH_RES, CFG_DATA_W'(hr));
    write_cfg(REG_RANGE, rng);
  endtask

  // Random raw word: mostly full range, sometimes zero, tiny or extreme
  function automatic logic [RAW_W-1:0] rand_raw();
    case ($urandom_range(9))
      0: return '0;
      1: return RAW_W'($urandom_range(127)) - 16'd63; // at most one count in hi-res
      2: return ($urandom_range(1)) ? 16'h7FFF : 16'h8000;
      default: return RAW_W'($urandom());
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Extremes and the special angle cases, at the reset scale, at low-res 8 g and at the unused range code
  task automatic test_directed;
    for (int pass = 0; pass < 2; pass++) begin
      if (pass == 1) begin
        drain();
        set_scale(1'b0, RANGE_8G);
      end
      send_sample(16'h0000, 16'h0000, 16'h0000); // zero vector
      send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_sample(16'h8000, 16'h8000, 16'h8000);
      send_sample(16'h0000, 16'h0000, 16'h4000); // on +z axis
      send_sample(16'h0000, 16'h0000, 16'hC000); // on -z axis
      send_sample(16'hC000, 16'h0000, 16'h1000); // y zero, x negative
      send_sample(16'h0000, 16'h0000, 16'h0040); // x and y zero
      send_sample(16'h0040, 16'hFFC0, 16'h0000);
      send_sample(16'h003F, 16'hFFC1, 16'h0001); // truncates to zero in hi-res
      send_sample(16'h1280, 16'hAB7F, 16'h5501); // upper byte ignored in lo-res
      send_sample(16'h0000, 16'h7FFF, 16'h0000);
    end
    drain();
    set_scale(1'b1, RANGE_ODD); // unused range code acts as 2 g
    send_sample(16'h7FFF, 16'h8000, 16'h1234);
    send_sample(16'h0000, 16'h0000, 16'h0000);
    drain();
  endtask

  // Random items across every scale setting
  task automatic test_random_scales(int n_per_cfg);
    for (int c = 0; c < 8; c++) begin
      drain();
      set_scale(c < 4, 2'(c));
      for (int i = 0; i < n_per_cfg; i++) send_sample(rand_raw(), rand_raw(), rand_raw());
    end
    drain();
  endtask

  // Receiver holds off long enough for the pipeline to fill and stall its input
  task automatic test_backpressure;
    send_idle_pct = 0;
    hold_req = 200;
    for (int i = 0; i < 120; i++) send_sample(rand_raw(), rand_raw(), rand_raw());
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 24;
    recv_idle_pct = 71;
    test_directed();
    test_random_scales(40);

    send_idle_pct = 71;
    recv_idle_pct = 24;
    test_random_scales(40);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_scales(40);
    test_backpressure();

    // Tail: let anything stray come out
    repeat (PIPE_LAT + 20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[files.f]
sv/ast_pkg.sv
sv/ast_if.sv
sv/ast_scale.sv
sv/ast_isqrt.sv
sv/ast_cordic.sv
sv/accel_sample_to_spherical_top.sv
tb/sv/accel_sample_to_spherical_top_test.sv
